[design/thsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thermocouple sample averager package
// Field layout of the converter word, result widths, fallbacks and the
// sequencer state type.
// ----------------------------------------------------------------------------
package thsa_pkg;

    localparam int WORD_W    = 32;
    localparam int TC_W      = 14;
    localparam int TC_LSB    = 18;
    localparam int CJ_W      = 12;
    localparam int CJ_LSB    = 4;
    localparam int FAULT_W   = 3;
    localparam int FRAC_SHIFT = 4;
    localparam int THERMO_W  = 19;
    localparam int JUNC_W    = 17;
    localparam int SHOW_W    = 16;

    localparam logic [WORD_W-1:0]   RESERVED_MASK   = 32'h0002_0008;
    localparam logic [THERMO_W-1:0] THERMO_FALLBACK = 19'd128000;
    localparam logic [JUNC_W-1:0]   JUNC_FALLBACK   = 17'd32768;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_AVERAGE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_PREP,
        ST_DIV_T,
        ST_FIN_T,
        ST_DIV_J,
        ST_FIN_J,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

[design/thermocouple_sample_averager_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thermocouple sample averager
// Stores converter words in a ring and averages the fault-free entries.
// ----------------------------------------------------------------------------
// A store word goes through the emit state into the output register. An average
// word walks the ring one entry a cycle, then runs a shared restoring divider
// one quotient bit a cycle, first for the thermocouple sum, then for the
// junction sum; when no entry is fault-free the divider is skipped and the
// fallback values are reported. in_ready is low while a word is in progress;
// the result sits in an output register until taken.
module thermocouple_sample_averager_unit #(
    parameter int SAMPLE_DEPTH = 8,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire                                   cmd,
    input  wire [thsa_pkg::WORD_W-1:0]            raw_word,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic                                  sample_rejected,
    output logic                                  average_valid,
    output logic [thsa_pkg::FAULT_W-1:0]          fault_flags,
    output logic signed [thsa_pkg::THERMO_W-1:0]  thermo_average,
    output logic signed [thsa_pkg::JUNC_W-1:0]    junction_average,
    output logic [thsa_pkg::SHOW_W-1:0]           rejected_count,
    output logic [thsa_pkg::SHOW_W-1:0]           faulty_count,
    output logic [thsa_pkg::SHOW_W-1:0]           failed_average_count
);

    localparam int IDX_W  = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int TS_W   = thsa_pkg::TC_W + CNT_W;
    localparam int JS_W   = thsa_pkg::CJ_W + CNT_W;
    localparam int DV_W   = TS_W + thsa_pkg::FRAC_SHIFT;
    localparam int STEP_W = $clog2(DV_W);
    localparam int CE_W   = (COUNT_WIDTH > thsa_pkg::SHOW_W) ? COUNT_WIDTH : thsa_pkg::SHOW_W;

    thsa_pkg::state_t state_reg, state_next;

    logic [thsa_pkg::WORD_W-1:0] ring_word_reg [SAMPLE_DEPTH];
    logic [SAMPLE_DEPTH-1:0]     ring_rej_reg;
    logic [IDX_W-1:0]            wr_idx_reg;

    logic [COUNT_WIDTH-1:0] rej_cnt_reg;
    logic [COUNT_WIDTH-1:0] flt_cnt_reg;
    logic [COUNT_WIDTH-1:0] fail_cnt_reg;

    logic                          last_valid_reg;
    logic [thsa_pkg::FAULT_W-1:0]  last_flags_reg;
    logic [thsa_pkg::THERMO_W-1:0] last_thermo_reg;
    logic [thsa_pkg::JUNC_W-1:0]   last_junc_reg;
    logic                          rej_reg;

    logic [IDX_W-1:0]             walk_idx_reg;
    logic signed [TS_W-1:0]       tsum_reg;
    logic signed [JS_W-1:0]       jsum_reg;
    logic [CNT_W-1:0]             n_reg;
    logic [thsa_pkg::FAULT_W-1:0] flags_reg;

    logic [DV_W-1:0]   div_q_reg;
    logic [CNT_W-1:0]  div_r_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;

    logic                          out_valid_reg;
    logic                          o_rej_reg;
    logic                          o_avg_valid_reg;
    logic [thsa_pkg::FAULT_W-1:0]  o_flags_reg;
    logic [thsa_pkg::THERMO_W-1:0] o_thermo_reg;
    logic [thsa_pkg::JUNC_W-1:0]   o_junc_reg;
    logic [thsa_pkg::SHOW_W-1:0]   o_rej_cnt_reg;
    logic [thsa_pkg::SHOW_W-1:0]   o_flt_cnt_reg;
    logic [thsa_pkg::SHOW_W-1:0]   o_fail_cnt_reg;

    logic in_accept;
    logic emit_load;
    logic walk_last;
    logic div_last;

    logic                          in_rej;
    logic                          in_faulty;
    logic [thsa_pkg::WORD_W-1:0]   ent_word;
    logic                          ent_rej;
    logic                          ent_take;
    logic [TS_W-1:0]               t_add;
    logic [JS_W-1:0]               j_add;
    logic [TS_W-1:0]               t_mag;
    logic [JS_W-1:0]               j_mag;
    logic [DV_W-1:0]               t_dvd;
    logic [DV_W-1:0]               j_dvd;
    logic [CNT_W:0]                r_shift;
    logic [CNT_W:0]                r_diff;
    logic                          r_ge;
    logic [CNT_W-1:0]              r_next;
    logic [DV_W-1:0]               q_next;
    logic [DV_W-1:0]               q_signed;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        sat_inc = (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [thsa_pkg::SHOW_W-1:0] show_count(
        input logic [COUNT_WIDTH-1:0] c
    );
        logic [CE_W-1:0] e;
        e = CE_W'(c);
        show_count = (e > CE_W'({thsa_pkg::SHOW_W{1'b1}})) ? {thsa_pkg::SHOW_W{1'b1}}
                                                           : e[thsa_pkg::SHOW_W-1:0];
    endfunction

    assign in_ready  = (state_reg == thsa_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign walk_last = (walk_idx_reg == IDX_W'(SAMPLE_DEPTH - 1));
    assign div_last  = (step_reg == '0);

    assign in_rej    = |(raw_word & thsa_pkg::RESERVED_MASK);
    assign in_faulty = !in_rej && (raw_word[thsa_pkg::FAULT_W-1:0] != '0);

    assign ent_word = ring_word_reg[walk_idx_reg];
    assign ent_rej  = ring_rej_reg[walk_idx_reg];
    assign ent_take = !ent_rej && (ent_word[thsa_pkg::FAULT_W-1:0] == '0);
    assign t_add = {{(TS_W - thsa_pkg::TC_W){ent_word[thsa_pkg::WORD_W-1]}},
                    ent_word[thsa_pkg::TC_LSB +: thsa_pkg::TC_W]};
    assign j_add = {{(JS_W - thsa_pkg::CJ_W){ent_word[thsa_pkg::CJ_LSB + thsa_pkg::CJ_W - 1]}},
                    ent_word[thsa_pkg::CJ_LSB +: thsa_pkg::CJ_W]};

    // magnitudes of the sums, scaled by 16 for the finer output units
    assign t_mag = tsum_reg[TS_W-1] ? (~tsum_reg + 1'b1) : tsum_reg;
    assign j_mag = jsum_reg[JS_W-1] ? (~jsum_reg + 1'b1) : jsum_reg;
    assign t_dvd = {t_mag, {thsa_pkg::FRAC_SHIFT{1'b0}}};
    assign j_dvd = {{(DV_W - JS_W - thsa_pkg::FRAC_SHIFT){1'b0}}, j_mag,
                    {thsa_pkg::FRAC_SHIFT{1'b0}}};

    // restoring divider, one quotient bit a cycle
    assign r_shift  = {div_r_reg, div_q_reg[DV_W-1]};
    assign r_diff   = r_shift - {1'b0, n_reg};
    assign r_ge     = (r_shift >= {1'b0, n_reg});
    assign r_next   = r_ge ? r_diff[CNT_W-1:0] : r_shift[CNT_W-1:0];
    assign q_next   = {div_q_reg[DV_W-2:0], r_ge};
    assign q_signed = neg_reg ? (~div_q_reg + 1'b1) : div_q_reg;

    always_comb
    begin
        state_next = state_reg;
        emit_load  = 1'b0;
        unique case (state_reg)
            thsa_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (cmd == thsa_pkg::CMD_AVERAGE) ? thsa_pkg::ST_WALK
                                                                : thsa_pkg::ST_EMIT;
                end
            end
            thsa_pkg::ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = thsa_pkg::ST_PREP;
                end
            end
            thsa_pkg::ST_PREP:
            begin
                state_next = (n_reg == '0) ? thsa_pkg::ST_EMIT : thsa_pkg::ST_DIV_T;
            end
            thsa_pkg::ST_DIV_T:
            begin
                if (div_last)
                begin
                    state_next = thsa_pkg::ST_FIN_T;
                end
            end
            thsa_pkg::ST_FIN_T:
            begin
                state_next = thsa_pkg::ST_DIV_J;
            end
            thsa_pkg::ST_DIV_J:
            begin
                if (div_last)
                begin
                    state_next = thsa_pkg::ST_FIN_J;
                end
            end
            thsa_pkg::ST_FIN_J:
            begin
                state_next = thsa_pkg::ST_EMIT;
            end
            thsa_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit_load  = 1'b1;
                    state_next = thsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = thsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= thsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ring, totals and last average
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SAMPLE_DEPTH; i++)
            begin
                ring_word_reg[i] <= '0;
            end
            ring_rej_reg    <= '0;
            wr_idx_reg      <= '0;
            rej_cnt_reg     <= '0;
            flt_cnt_reg     <= '0;
            fail_cnt_reg    <= '0;
            last_valid_reg  <= 1'b0;
            last_flags_reg  <= '0;
            last_thermo_reg <= '0;
            last_junc_reg   <= '0;
            rej_reg         <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (cmd == thsa_pkg::CMD_STORE)
                begin
                    ring_word_reg[wr_idx_reg] <= raw_word;
                    ring_rej_reg[wr_idx_reg]  <= in_rej;
                    rej_reg                   <= in_rej;
                    wr_idx_reg <= (wr_idx_reg == IDX_W'(SAMPLE_DEPTH - 1)) ? '0
                                                                          : wr_idx_reg + 1'b1;
                    if (in_rej)
                    begin
                        rej_cnt_reg <= sat_inc(rej_cnt_reg);
                    end
                    if (in_faulty)
                    begin
                        flt_cnt_reg <= sat_inc(flt_cnt_reg);
                    end
                end
                else
                begin
                    rej_reg <= 1'b0;
                end
            end
            if ((state_reg == thsa_pkg::ST_PREP) && (n_reg == '0))
            begin
                last_valid_reg  <= 1'b0;
                last_flags_reg  <= flags_reg;
                last_thermo_reg <= thsa_pkg::THERMO_FALLBACK;
                last_junc_reg   <= thsa_pkg::JUNC_FALLBACK;
                fail_cnt_reg    <= sat_inc(fail_cnt_reg);
            end
            if (state_reg == thsa_pkg::ST_FIN_T)
            begin
                last_thermo_reg <= q_signed[thsa_pkg::THERMO_W-1:0];
            end
            if (state_reg == thsa_pkg::ST_FIN_J)
            begin
                last_valid_reg <= 1'b1;
                last_flags_reg <= '0;
                last_junc_reg  <= q_signed[thsa_pkg::JUNC_W-1:0];
            end
        end
    end

    // walk accumulators and divider
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            walk_idx_reg <= '0;
            tsum_reg     <= '0;
            jsum_reg     <= '0;
            n_reg        <= '0;
            flags_reg    <= '0;
        end
        unique case (state_reg)
            thsa_pkg::ST_WALK:
            begin
                walk_idx_reg <= walk_idx_reg + 1'b1;
                if (!ent_rej)
                begin
                    flags_reg <= flags_reg | ent_word[thsa_pkg::FAULT_W-1:0];
                end
                if (ent_take)
                begin
                    tsum_reg <= tsum_reg + $signed(t_add);
                    jsum_reg <= jsum_reg + $signed(j_add);
                    n_reg    <= n_reg + 1'b1;
                end
            end
            thsa_pkg::ST_PREP:
            begin
                div_q_reg <= t_dvd;
                div_r_reg <= '0;
                neg_reg   <= tsum_reg[TS_W-1];
                step_reg  <= STEP_W'(DV_W - 1);
            end
            thsa_pkg::ST_FIN_T:
            begin
                div_q_reg <= j_dvd;
                div_r_reg <= '0;
                neg_reg   <= jsum_reg[JS_W-1];
                step_reg  <= STEP_W'(DV_W - 1);
            end
            thsa_pkg::ST_DIV_T, thsa_pkg::ST_DIV_J:
            begin
                div_q_reg <= q_next;
                div_r_reg <= r_next;
                step_reg  <= step_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            o_rej_reg       <= rej_reg;
            o_avg_valid_reg <= last_valid_reg;
            o_flags_reg     <= last_flags_reg;
            o_thermo_reg    <= last_thermo_reg;
            o_junc_reg      <= last_junc_reg;
            o_rej_cnt_reg   <= show_count(rej_cnt_reg);
            o_flt_cnt_reg   <= show_count(flt_cnt_reg);
            o_fail_cnt_reg  <= show_count(fail_cnt_reg);
        end
    end

    assign out_valid            = out_valid_reg;
    assign sample_rejected      = o_rej_reg;
    assign average_valid        = o_avg_valid_reg;
    assign fault_flags          = o_flags_reg;
    assign thermo_average       = $signed(o_thermo_reg);
    assign junction_average     = $signed(o_junc_reg);
    assign rejected_count       = o_rej_cnt_reg;
    assign faulty_count         = o_flt_cnt_reg;
    assign failed_average_count = o_fail_cnt_reg;

    a_valid_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && average_valid |-> fault_flags == '0)
        else $error("valid average reported with fault flags");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == thsa_pkg::ST_DIV_T || state_reg == thsa_pkg::ST_DIV_J)
        |-> div_r_reg < n_reg)
        else $error("divider remainder not below divisor");

    a_avg_walks: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (cmd == thsa_pkg::CMD_AVERAGE) |=> state_reg == thsa_pkg::ST_WALK)
        else $error("average word did not start the ring walk");

    a_rej_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_rejected |-> rejected_count != '0)
        else $error("rejected word without a rejected count");

endmodule
`default_nettype wire
